[rtl/core/kmp_pattern_search_unit_macros.svh]
// ----------------------------------------------------------------------------
// KMP pattern search assertion macros
// Shared assertion forms for the pattern search block.
// ----------------------------------------------------------------------------
`ifndef KMP_PATTERN_SEARCH_UNIT_MACROS_SVH
`define KMP_PATTERN_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define KMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define KMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/kmp_pkg.sv]
// ----------------------------------------------------------------------------
// KMP pattern search package
// Types and constants shared by the pattern search block.
// ----------------------------------------------------------------------------
package kmp_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_TEXT    = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } req_t;

    typedef struct packed {
        logic found;
        logic pattern_invalid;
    } rsp_t;

endpackage

[rtl/core/kmp_pattern_search_unit.sv]
// ----------------------------------------------------------------------------
// KMP pattern search unit
// Streaming Knuth-Morris-Pratt matcher with on-the-fly failure table build.
// ----------------------------------------------------------------------------
// A request is either a pattern byte or a text byte. Both walk the failure
// chain through one shared compare step on a single read port of the pattern
// and failure memories, one chain step per cycle. A request is taken in the
// idle state and, where it needs a walk, steps the chain in the compare state;
// a text byte marked last then passes through the emit state to post its result.
// Requests are stalled outside the idle state; a waiting result holds up only
// the post of a later result. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`include "kmp_pattern_search_unit_macros.svh"

module kmp_pattern_search_unit
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  kmp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output kmp_pkg::rsp_t rsp
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [kmp_pkg::CNT_W-1:0] MAX_CNT = kmp_pkg::CNT_W'(kmp_pkg::MAX_PATTERN);
    localparam logic [kmp_pkg::CNT_W-1:0] ONE_CNT = kmp_pkg::CNT_W'(1);

    logic [7:0]                pat_mem  [kmp_pkg::MAX_PATTERN];
    logic [kmp_pkg::CNT_W-1:0] fail_mem [kmp_pkg::MAX_PATTERN];

    logic [1:0]                state_reg,    state_next;
    logic [kmp_pkg::CNT_W-1:0] count_reg,    count_next;
    logic                      overflow_reg, overflow_next;
    logic [kmp_pkg::CNT_W-1:0] pos_reg,      pos_next;
    logic                      found_reg,    found_next;
    logic [kmp_pkg::CNT_W-1:0] walk_reg,     walk_next;
    logic [kmp_pkg::CNT_W-1:0] prev_fail_reg, prev_fail_next;
    logic [7:0]                prev_byte_reg, prev_byte_next;
    logic                      mode_reg,     mode_next;
    logic [7:0]                byte_reg,     byte_next;
    logic                      last_reg,     last_next;
    logic [kmp_pkg::IDX_W-1:0] idx_reg,      idx_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    kmp_pkg::rsp_t             rsp_reg,      rsp_next;

    logic [7:0]                rd_pat_reg;
    logic [kmp_pkg::CNT_W-1:0] rd_fail_reg;
    logic [kmp_pkg::IDX_W-1:0] rd_addr;

    logic                      pat_we;
    logic [kmp_pkg::IDX_W-1:0] pat_waddr;
    logic                      fail_we;
    logic [kmp_pkg::IDX_W-1:0] fail_waddr;
    logic [kmp_pkg::CNT_W-1:0] fail_wdata;

    logic                      req_fire;
    logic                      pat_valid;
    logic [kmp_pkg::CNT_W-1:0] cnt_sel;
    logic [kmp_pkg::CNT_W-1:0] k_sel;
    logic [kmp_pkg::CNT_W-1:0] fail_dec;
    logic [kmp_pkg::CNT_W-1:0] prev_fail_dec;
    logic [kmp_pkg::CNT_W-1:0] walk_inc;
    logic [7:0]                cmp_byte;
    logic                      cmp_eq;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign pat_valid     = (count_reg != '0) && !overflow_reg;
    assign cnt_sel       = req.first ? '0 : count_reg;
    assign k_sel         = req.first ? '0 : pos_reg;
    assign fail_dec      = rd_fail_reg - ONE_CNT;
    assign prev_fail_dec = prev_fail_reg - ONE_CNT;
    assign walk_inc      = walk_reg + ONE_CNT;
    assign cmp_byte      = (mode_reg == kmp_pkg::MODE_TEXT) ? byte_reg : prev_byte_reg;
    assign cmp_eq        = (rd_pat_reg == cmp_byte);

    always_comb
    begin
        if (state_reg == ST_CMP)
        begin
            rd_addr = fail_dec[kmp_pkg::IDX_W-1:0];
        end
        else if (req.mode == kmp_pkg::MODE_TEXT)
        begin
            rd_addr = k_sel[kmp_pkg::IDX_W-1:0];
        end
        else
        begin
            rd_addr = prev_fail_dec[kmp_pkg::IDX_W-1:0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        walk_next      = walk_reg;
        prev_fail_next = prev_fail_reg;
        prev_byte_next = prev_byte_reg;
        mode_next      = mode_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        idx_next       = idx_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        pat_we         = 1'b0;
        pat_waddr      = cnt_sel[kmp_pkg::IDX_W-1:0];
        fail_we        = 1'b0;
        fail_waddr     = idx_reg;
        fail_wdata     = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    mode_next = req.mode;
                    byte_next = req.data_byte;
                    last_next = req.last;
                    if (req.mode == kmp_pkg::MODE_PATTERN)
                    begin
                        pos_next = '0;
                        if (cnt_sel >= MAX_CNT)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            overflow_next = req.first ? 1'b0 : overflow_reg;
                            count_next    = cnt_sel + ONE_CNT;
                            pat_we        = 1'b1;
                            idx_next      = cnt_sel[kmp_pkg::IDX_W-1:0];
                            if (cnt_sel == '0)
                            begin
                                fail_we        = 1'b1;
                                fail_waddr     = cnt_sel[kmp_pkg::IDX_W-1:0];
                                fail_wdata     = '0;
                                prev_fail_next = '0;
                                prev_byte_next = req.data_byte;
                            end
                            else if (prev_fail_reg == '0)
                            begin
                                fail_we        = 1'b1;
                                fail_waddr     = cnt_sel[kmp_pkg::IDX_W-1:0];
                                fail_wdata     = ONE_CNT;
                                prev_fail_next = ONE_CNT;
                                prev_byte_next = req.data_byte;
                            end
                            else
                            begin
                                walk_next  = prev_fail_reg;
                                state_next = ST_CMP;
                            end
                        end
                    end
                    else
                    begin
                        if (req.first)
                        begin
                            found_next = 1'b0;
                            pos_next   = '0;
                        end
                        if (pat_valid && (k_sel < count_reg))
                        begin
                            walk_next  = k_sel + ONE_CNT;
                            state_next = ST_CMP;
                        end
                        else
                        begin
                            if (pat_valid)
                            begin
                                pos_next = '0;
                            end
                            if (req.last)
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                end
            end

            ST_CMP:
            begin
                if (mode_reg == kmp_pkg::MODE_PATTERN)
                begin
                    if (cmp_eq || (rd_fail_reg == '0))
                    begin
                        fail_we        = 1'b1;
                        fail_waddr     = idx_reg;
                        fail_wdata     = cmp_eq ? walk_inc : ONE_CNT;
                        prev_fail_next = fail_wdata;
                        prev_byte_next = byte_reg;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        walk_next = rd_fail_reg;
                    end
                end
                else
                begin
                    if (cmp_eq)
                    begin
                        if (walk_reg == count_reg)
                        begin
                            found_next = 1'b1;
                            pos_next   = '0;
                        end
                        else
                        begin
                            pos_next = walk_reg;
                        end
                        state_next = last_reg ? ST_EMIT : ST_IDLE;
                    end
                    else if ((rd_fail_reg == '0) || (rd_fail_reg > count_reg))
                    begin
                        pos_next   = '0;
                        state_next = last_reg ? ST_EMIT : ST_IDLE;
                    end
                    else
                    begin
                        walk_next = rd_fail_reg;
                    end
                end
            end

            ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next          = 1'b1;
                    rsp_next.found          = found_reg && pat_valid;
                    rsp_next.pattern_invalid = !pat_valid;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
        begin
            pat_mem[pat_waddr] <= req.data_byte;
        end
        if (fail_we)
        begin
            fail_mem[fail_waddr] <= fail_wdata;
        end
        rd_pat_reg  <= pat_mem[rd_addr];
        rd_fail_reg <= fail_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            prev_fail_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            prev_fail_reg <= prev_fail_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg      <= walk_next;
        prev_byte_reg <= prev_byte_next;
        mode_reg      <= mode_next;
        byte_reg      <= byte_next;
        last_reg      <= last_next;
        idx_reg       <= idx_next;
        rsp_reg       <= rsp_next;
    end

    `KMP_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= MAX_CNT, "pattern count exceeds store depth")
    `KMP_ASSERT_IMP(a_overflow_full, overflow_reg, count_reg == MAX_CNT, "overflow with store not full")
    `KMP_ASSERT_IMP(a_pos_bound, pos_reg != '0, pos_reg < count_reg, "match position beyond pattern")
    `KMP_ASSERT_IMP(a_walk_live, state_reg == ST_CMP, walk_reg != '0, "chain walk at empty prefix")
    `KMP_ASSERT_NXT(a_rsp_hold, rsp_valid_reg && rsp_stall, rsp_valid_reg, "stalled result dropped")

endmodule

[sim/tb_kmp_pattern_search_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// KMP pattern search unit testbench
// Loads patterns and streams text packets through the search unit. The
// scoreboard keeps its own pattern and failure tables and its own matcher,
// so it can predict the verdict of each packet. It then compares every
// response, field by field, with the oldest verdict still waiting.
// ----------------------------------------------------------------------------
module tb_kmp_pattern_search_unit;

    class kmp_verdict_board;

        logic [7:0]    pattern_bytes [kmp_pkg::MAX_PATTERN];
        int            failure_links [kmp_pkg::MAX_PATTERN];
        int            pattern_len;
        bit            dropped_byte;
        int            matched_len;
        bit            seen_match;
        kmp_pkg::rsp_t verdicts [$];
        int            mismatches;

        function new();
            foreach (pattern_bytes[i])
            begin
                pattern_bytes[i] = 8'h00;
                failure_links[i] = 0;
            end
            pattern_len  = 0;
            dropped_byte = 1'b0;
            matched_len  = 0;
            seen_match   = 1'b0;
            mismatches   = 0;
        endfunction

        function void load_pattern_byte(logic [7:0] b, bit start);
            int         k;
            logic [7:0] prev;
            if (start)
            begin
                pattern_len  = 0;
                dropped_byte = 1'b0;
            end
            matched_len = 0;
            if (pattern_len >= kmp_pkg::MAX_PATTERN)
            begin
                dropped_byte = 1'b1;
                return;
            end
            pattern_bytes[pattern_len] = b;
            if (pattern_len == 0)
            begin
                failure_links[0] = -1;
            end
            else
            begin
                prev = pattern_bytes[pattern_len - 1];
                k    = failure_links[pattern_len - 1];
                while (k >= 0 && k < kmp_pkg::MAX_PATTERN && pattern_bytes[k] != prev)
                    k = failure_links[k];
                failure_links[pattern_len] = k + 1;
            end
            pattern_len++;
        endfunction

        function void advance_match(logic [7:0] b);
            int k;
            bit done;
            k    = matched_len;
            done = 1'b0;
            while (!done)
            begin
                if (k < 0 || k >= pattern_len)
                begin
                    k    = 0;
                    done = 1'b1;
                end
                else if (b == pattern_bytes[k])
                begin
                    k++;
                    if (k == pattern_len)
                    begin
                        seen_match = 1'b1;
                        k          = 0;
                    end
                    done = 1'b1;
                end
                else
                begin
                    k = failure_links[k];
                end
            end
            matched_len = k;
        endfunction

        function void note_request(kmp_pkg::req_t r);
            bit            usable;
            kmp_pkg::rsp_t v;
            if (r.mode == kmp_pkg::MODE_PATTERN)
            begin
                load_pattern_byte(r.data_byte, r.first);
                return;
            end
            if (r.first)
            begin
                matched_len = 0;
                seen_match  = 1'b0;
            end
            usable = (pattern_len > 0) && !dropped_byte;
            if (usable)
                advance_match(r.data_byte);
            if (r.last)
            begin
                v.found           = seen_match && usable;
                v.pattern_invalid = !usable;
                verdicts.push_back(v);
            end
        endfunction

        task report(string what);
            $display("ERROR at %0t ns: %s", $time, what);
            mismatches++;
        endtask

        task check_verdict(kmp_pkg::rsp_t got);
            kmp_pkg::rsp_t want;
            if (verdicts.size() == 0)
            begin
                report("response with no verdict waiting");
                return;
            end
            want = verdicts.pop_front();
            if (got.found !== want.found)
                report($sformatf("found is %b, expected %b", got.found, want.found));
            if (got.pattern_invalid !== want.pattern_invalid)
                report($sformatf("pattern_invalid is %b, expected %b",
                                 got.pattern_invalid, want.pattern_invalid));
        endtask

    endclass

    localparam int RANDOM_ITEMS = 450;

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          req_valid = 1'b0;
    logic          req_stall;
    kmp_pkg::req_t req       = '0;
    logic          rsp_valid;
    logic          rsp_stall = 1'b0;
    kmp_pkg::rsp_t rsp;

    kmp_verdict_board board = new();
    int               sent  = 0;
    bit               steady = 1'b0;

    kmp_pattern_search_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
        rsp_stall <= !steady && ($urandom_range(0, 99) < 21);

    always @(posedge clk)
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_verdict(rsp);

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send(logic mode, logic [7:0] b, logic first, logic last);
        kmp_pkg::req_t r;
        r.mode      = mode;
        r.data_byte = b;
        r.first     = first;
        r.last      = last;
        if (!steady && $urandom_range(0, 99) < 21)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
        sent++;
        @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] alpha [2];
        logic [7:0] motif [$];
        logic [7:0] txt [$];
        logic [7:0] b;
        int         pick;
        int         len;
        int         n;
        bit         drained;

        drained = 1'b0;
        alpha[0] = 8'h61;
        alpha[1] = 8'h62;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Text against an empty pattern, then a pattern started without a mark.
        send(kmp_pkg::MODE_TEXT,    8'h00, 1'b1, 1'b1);
        send(kmp_pkg::MODE_PATTERN, 8'hFF, 1'b0, 1'b0);
        send(kmp_pkg::MODE_PATTERN, 8'h00, 1'b0, 1'b1);
        send(kmp_pkg::MODE_TEXT,    8'hFF, 1'b1, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'h00, 1'b0, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'h55, 1'b0, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'hFF, 1'b0, 1'b1);
        // A packet continued without a start mark keeps its position and flag.
        send(kmp_pkg::MODE_TEXT,    8'h00, 1'b0, 1'b1);
        // A pattern byte in the middle of a packet clears the position.
        send(kmp_pkg::MODE_TEXT,    8'hFF, 1'b1, 1'b0);
        send(kmp_pkg::MODE_PATTERN, 8'h00, 1'b0, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'h00, 1'b0, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'hFF, 1'b0, 1'b1);
        // Self-overlapping pattern exercises the failure chain.
        send(kmp_pkg::MODE_PATTERN, 8'h61, 1'b1, 1'b1);
        send(kmp_pkg::MODE_PATTERN, 8'h61, 1'b0, 1'b0);
        send(kmp_pkg::MODE_PATTERN, 8'h62, 1'b0, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'h61, 1'b1, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'h61, 1'b0, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'h61, 1'b0, 1'b0);
        send(kmp_pkg::MODE_TEXT,    8'h62, 1'b0, 1'b1);
        send(kmp_pkg::MODE_TEXT,    8'h61, 1'b1, 1'b1);
        motif = '{8'h61, 8'h61, 8'h62};

        n = sent + RANDOM_ITEMS;
        while (sent < n)
        begin
            steady = (sent >= 150 && sent < 260);
            if (!drained && sent >= 300)
            begin
                drained = 1'b1;
                req_valid <= 1'b0;
                @(negedge clk);
                while (board.verdicts.size() != 0)
                    @(negedge clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    len = $urandom_range(1, 6);
                else if (pick < 95)
                    len = $urandom_range(29, kmp_pkg::MAX_PATTERN);
                else
                    len = $urandom_range(kmp_pkg::MAX_PATTERN + 1, kmp_pkg::MAX_PATTERN + 3);
                alpha[0] = 8'($urandom_range(0, 255));
                alpha[1] = 8'($urandom_range(0, 255));
                motif.delete();
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        b = 8'($urandom_range(0, 255));
                    else
                        b = alpha[$urandom_range(0, 1)];
                    send(kmp_pkg::MODE_PATTERN, b, (i == 0) && ($urandom_range(0, 19) != 0),
                         1'($urandom_range(0, 1)));
                    if (motif.size() < kmp_pkg::MAX_PATTERN)
                        motif.push_back(b);
                end
            end
            else if (pick < 92)
            begin
                len = $urandom_range(1, 6) + motif.size();
                txt.delete();
                while (txt.size() < len)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                    begin
                        foreach (motif[i])
                            txt.push_back(motif[i]);
                        if ($urandom_range(0, 9) < 3)
                            txt[txt.size() - 1] = alpha[$urandom_range(0, 1)];
                    end
                    else if (pick < 85)
                        txt.push_back(alpha[$urandom_range(0, 1)]);
                    else
                        txt.push_back(8'($urandom_range(0, 255)));
                end
                foreach (txt[i])
                begin
                    if (i > 0 && $urandom_range(0, 39) == 0)
                        send(kmp_pkg::MODE_PATTERN, 8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    send(kmp_pkg::MODE_TEXT, txt[i], (i == 0) && ($urandom_range(0, 19) != 0),
                         (i == txt.size() - 1) && ($urandom_range(0, 19) != 0));
                end
            end
            else
            begin
                send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        steady = 1'b0;
        req_valid <= 1'b0;

        for (int i = 0; i < 30000 && board.verdicts.size() != 0; i++)
            @(posedge clk);
        repeat (2 * kmp_pkg::MAX_PATTERN + 8) @(posedge clk);
        if (board.verdicts.size() != 0)
            board.report($sformatf("%0d verdicts never answered", board.verdicts.size()));

        if (board.mismatches == 0)
            $display("kmp_pattern_search_unit: match");
        else
            $display("kmp_pattern_search_unit: mismatch");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("kmp_pattern_search_unit: mismatch");
        $finish;
    end

endmodule
